### rtl/morse_key_timing_decoder_assert.svh
// ----------------------------------------------------------------------------
// Morse key timing decoder assertion macros
// Shared property macros for the decoder's internal checks.
// ----------------------------------------------------------------------------
`ifndef MORSE_KEY_TIMING_DECODER_ASSERT_SVH
`define MORSE_KEY_TIMING_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MKTD_ASSERT_SAME(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MKTD_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/mktd_pkg.sv
// ----------------------------------------------------------------------------
// Morse key timing decoder package
// Widths, result kinds, reset thresholds and the letter lookup.
// ----------------------------------------------------------------------------
package mktd_pkg;

    localparam int STAMP_W    = 16;
    localparam int LETTER_W   = 7;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_ELEMS  = 5;
    localparam int COUNT_W    = 3;
    localparam int CODE_W     = 5;

    typedef logic [STAMP_W-1:0]  stamp_t;
    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam kind_t KIND_DOT    = 2'd0;
    localparam kind_t KIND_DASH   = 2'd1;
    localparam kind_t KIND_LETTER = 2'd2;

    localparam cfg_idx_t REG_DOT_MIN  = 2'd0;
    localparam cfg_idx_t REG_DASH_MIN = 2'd1;
    localparam cfg_idx_t REG_DASH_MAX = 2'd2;
    localparam cfg_idx_t REG_GAP_MIN  = 2'd3;

    localparam stamp_t DOT_MIN_RST  = 16'd470;
    localparam stamp_t DASH_MIN_RST = 16'd3125;
    localparam stamp_t DASH_MAX_RST = 16'd9375;
    localparam stamp_t GAP_MIN_RST  = 16'd9375;
    localparam stamp_t TIME_RST     = 16'hFFFF;

    localparam count_t COUNT_MAX  = 3'd5;
    // A leading one marks the pattern length; the first element ends up highest.
    localparam code_t  CODE_EMPTY = 5'b00001;

    // Maps a sentinel-prefixed pattern of one to four elements to ASCII.
    function automatic letter_t letter_lookup(input code_t code);
        logic [7:0] ch;
        begin
            case (code)
                5'd2:    ch = "E";
                5'd3:    ch = "T";
                5'd4:    ch = "I";
                5'd5:    ch = "A";
                5'd6:    ch = "N";
                5'd7:    ch = "M";
                5'd8:    ch = "S";
                5'd9:    ch = "U";
                5'd10:   ch = "R";
                5'd11:   ch = "W";
                5'd12:   ch = "D";
                5'd13:   ch = "K";
                5'd14:   ch = "G";
                5'd15:   ch = "O";
                5'd16:   ch = "H";
                5'd17:   ch = "V";
                5'd18:   ch = "F";
                5'd20:   ch = "L";
                5'd22:   ch = "P";
                5'd23:   ch = "J";
                5'd24:   ch = "B";
                5'd25:   ch = "X";
                5'd26:   ch = "C";
                5'd27:   ch = "Y";
                5'd28:   ch = "Z";
                5'd29:   ch = "Q";
                default: ch = "?";
            endcase
            letter_lookup = ch[LETTER_W-1:0];
        end
    endfunction

endpackage

### rtl/morse_key_timing_decoder.sv
// ----------------------------------------------------------------------------
// Morse key timing decoder
// Classifies key press durations as dots or dashes and emits a letter once
// the idle gap before the next press is long enough.
//
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser: pressed, s_tdata: stamp
// m_        out  m_tvalid/m_tready  m_tuser: kind, m_tdata: letter
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// One key edge per cycle is taken while the result register is not stalled; each
// beat passes from the input register to the result register, where a result
// beat is offered until it is taken.
// Edges that give no result free the pipeline without producing a beat.
// Reset (aresetn, synchronous, active low) restores the default thresholds,
// both timestamps to all ones and an empty element buffer.
// A stalled result register holds the input register, and s_tready falls.
// ----------------------------------------------------------------------------
`include "morse_key_timing_decoder_assert.svh"

module morse_key_timing_decoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,   // [15:0] stamp
    input  logic                      s_tuser,   // [0] pressed
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // [6:0] letter, [7] zero
    output logic [1:0]                m_tuser,   // [1:0] kind
    input  logic                      cfg_wr_en,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_wdata
);
    import mktd_pkg::*;

    stamp_t  dot_min_reg, dash_min_reg, dash_max_reg, gap_min_reg;
    stamp_t  press_time_reg, release_time_reg;
    count_t  count_reg;
    code_t   code_reg;

    logic    in_valid_reg;
    logic    pressed_reg;
    stamp_t  stamp_reg;

    logic    out_valid_reg;
    kind_t   kind_reg;
    letter_t letter_reg;

    logic    out_free;
    logic    advance;
    stamp_t  gap;
    stamp_t  hold;
    logic    is_dot;
    logic    is_dash;
    logic    emit_letter;
    logic    store_elem;
    count_t  count_next;
    code_t   code_next;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign gap  = stamp_reg - release_time_reg;
    assign hold = stamp_reg - press_time_reg;

    assign is_dot      = (hold > dot_min_reg) && (hold < dash_min_reg);
    assign is_dash     = !is_dot && (hold >= dash_min_reg) && (hold <= dash_max_reg);
    assign emit_letter = pressed_reg && (gap > gap_min_reg) && (count_reg != '0);
    assign store_elem  = !pressed_reg && (is_dot || is_dash) && (count_reg < COUNT_MAX);

    always_comb begin
        count_next = count_reg;
        code_next  = code_reg;
        if (emit_letter) begin
            count_next = '0;
            code_next  = CODE_EMPTY;
        end else if (store_elem) begin
            count_next = count_reg + 3'd1;
            code_next  = {code_reg[CODE_W-2:0], is_dash};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_min_reg      <= DOT_MIN_RST;
            dash_min_reg     <= DASH_MIN_RST;
            dash_max_reg     <= DASH_MAX_RST;
            gap_min_reg      <= GAP_MIN_RST;
            press_time_reg   <= TIME_RST;
            release_time_reg <= TIME_RST;
            count_reg        <= '0;
            code_reg         <= CODE_EMPTY;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_DOT_MIN:  dot_min_reg  <= cfg_wdata;
                    REG_DASH_MIN: dash_min_reg <= cfg_wdata;
                    REG_DASH_MAX: dash_max_reg <= cfg_wdata;
                    REG_GAP_MIN:  gap_min_reg  <= cfg_wdata;
                    default:      dot_min_reg  <= dot_min_reg;
                endcase
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                count_reg     <= count_next;
                code_reg      <= code_next;
                out_valid_reg <= emit_letter || (!pressed_reg && (is_dot || is_dash));
                if (pressed_reg) begin
                    press_time_reg <= stamp_reg;
                end else begin
                    release_time_reg <= stamp_reg;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pressed_reg <= s_tuser;
            stamp_reg   <= s_tdata;
        end
        if (advance) begin
            if (pressed_reg) begin
                kind_reg   <= KIND_LETTER;
                letter_reg <= (count_reg < COUNT_MAX) ? letter_lookup(code_reg)
                                                      : letter_lookup('0);
            end else begin
                kind_reg   <= is_dot ? KIND_DOT : KIND_DASH;
                letter_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {1'b0, letter_reg};

    `MKTD_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= COUNT_MAX, "element count above five")
    `MKTD_ASSERT_SAME(a_empty_code, aclk, aresetn, count_reg == '0, code_reg == CODE_EMPTY, "empty buffer holds a pattern")
    `MKTD_ASSERT_NEXT(a_letter_clears, aclk, aresetn, advance && emit_letter, count_reg == '0 && m_tvalid, "letter beat did not clear the buffer")
    `MKTD_ASSERT_SAME(a_elem_no_letter, aclk, aresetn, m_tvalid && m_tuser != KIND_LETTER, m_tdata == 8'd0, "element beat carries a letter")

endmodule
